[hdl/smooth_l1_loss_reduce_core_macros.svh]
// ----------------------------------------------------------------------------
// Smooth L1 loss reduce core: assertion macros
// Clocked assertion helpers that share the clk / rst_n names of the core.
// Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef SMOOTH_L1_LOSS_REDUCE_CORE_MACROS_SVH
`define SMOOTH_L1_LOSS_REDUCE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SLR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SLR_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SLR_ASSERT(lbl, prop, msg)
`define SLR_NEVER(lbl, cond, msg)
`endif
`endif

[hdl/slr_pkg.sv]
// ----------------------------------------------------------------------------
// Smooth L1 loss reduce package
// Shared types and constants: queue entry, register set, sequencer states.
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam logic [47:0] CAP47   = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] CAP48   = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] NEG_MIN = 48'h8000_0000_0000;

    typedef enum logic [1:0] {
        REG_SIGMA_SQ,
        REG_INV_SIGMA_SQ,
        REG_INV_BATCH,
        REG_USE_WEIGHTS
    } slr_reg_idx_t;

    typedef struct packed {
        logic [32:0] diff_mag;
        logic [31:0] iw_mag;
        logic [31:0] ow_mag;
        logic        ow_neg;
        logic        last;
    } slr_item_t;

    typedef struct packed {
        logic [30:0] sigma_sq;
        logic [31:0] inv_sigma_sq;
        logic [16:0] inv_batch;
        logic        use_weights;
    } slr_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WMUL,
        ST_WFIX,
        ST_CLASS,
        ST_QSQ,
        ST_QLO,
        ST_QHI,
        ST_QFIX,
        ST_OLO,
        ST_OHI,
        ST_OFIX,
        ST_ACC,
        ST_FMAG,
        ST_FLO,
        ST_FHI,
        ST_FFIX
    } slr_state_t;

endpackage

[hdl/slr_front.sv]
// ----------------------------------------------------------------------------
// Smooth L1 loss reduce front end
// Accepts elements, forms |prediction - target|, the weight magnitudes and
// the outside weight sign, and writes the entry into the queue.
// ----------------------------------------------------------------------------
module slr_front
    import slr_pkg::*;
(
    input  logic               push,
    input  logic               full,
    input  logic signed [31:0] prediction,
    input  logic signed [31:0] target,
    input  logic signed [31:0] inside_weight,
    input  logic signed [31:0] outside_weight,
    input  logic               last_element,
    output logic               item_wr,
    output slr_item_t          item
);

    logic signed [32:0] diff;

    assign diff    = 33'(prediction) - 33'(target);
    assign item_wr = push & ~full;

    always_comb
    begin
        item.diff_mag = diff[32] ? $unsigned(-diff) : $unsigned(diff);
        item.iw_mag   = inside_weight[31] ? $unsigned(-inside_weight)
                                          : $unsigned(inside_weight);
        item.ow_mag   = outside_weight[31] ? $unsigned(-outside_weight)
                                           : $unsigned(outside_weight);
        item.ow_neg   = outside_weight[31];
        item.last     = last_element;
    end

endmodule

[hdl/slr_queue.sv]
// ----------------------------------------------------------------------------
// Smooth L1 loss reduce queue
// Short register queue between front end and back end.
// ----------------------------------------------------------------------------
`include "smooth_l1_loss_reduce_core_macros.svh"

module slr_queue
    import slr_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  slr_item_t wr_item,
    output logic      full,
    input  logic      rd,
    output slr_item_t rd_item,
    output logic      empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    slr_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr, rd})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `SLR_NEVER(a_full_and_empty, full && empty, "queue full and empty at once")
    `SLR_ASSERT(a_cnt_max, cnt_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `SLR_ASSERT(a_wr_fills, (wr && !rd) |=> !empty, "queue write lost")

endmodule

[hdl/slr_back.sv]
// ----------------------------------------------------------------------------
// Smooth L1 loss reduce back end
// Sequencer around one shared 33x32 multiplier: weighting, smooth L1,
// outside weighting, saturating accumulation and final scaling.
// ----------------------------------------------------------------------------
`include "smooth_l1_loss_reduce_core_macros.svh"

module slr_back
    import slr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  slr_cfg_t    cfg,
    input  logic        q_empty,
    input  slr_item_t   q_item,
    output logic        q_rd,
    input  logic        pop,
    output logic        empty,
    output logic [47:0] loss
);

    slr_state_t  state_reg;
    slr_state_t  state_next;
    logic [47:0] m_reg;
    logic [47:0] m_next;
    logic [31:0] iw_reg;
    logic [31:0] iw_next;
    logic [31:0] ow_reg;
    logic [31:0] ow_next;
    logic        ow_neg_reg;
    logic        ow_neg_next;
    logic        last_reg;
    logic        last_next;
    logic [64:0] p_reg;
    logic [31:0] hi_reg;
    logic [31:0] hi_next;
    logic [47:0] lo_reg;
    logic [47:0] lo_next;
    logic [46:0] e_reg;
    logic [46:0] e_next;
    logic [47:0] sum_reg;
    logic [47:0] sum_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [47:0] loss_reg;
    logic [47:0] loss_next;

    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_en;
    logic        emit;

    logic        m_lt;
    logic [47:0] lin;
    logic [46:0] lin_sat;
    logic [48:0] q_sum;
    logic [47:0] q_r;
    logic [48:0] o_sum;
    logic [46:0] o_sat;
    logic [48:0] contrib;
    logic [48:0] acc_sum;
    logic [47:0] acc_sat;
    logic [50:0] f_sum;
    logic        f_big;
    logic        f_over;
    logic [47:0] f_loss;

    assign empty = ~res_valid_reg;
    assign loss  = loss_reg;
    assign emit  = (state_reg == ST_FFIX) && (!res_valid_reg || pop);

    assign m_lt    = m_reg < {16'b0, cfg.inv_sigma_sq};
    assign lin     = m_reg - {17'b0, cfg.inv_sigma_sq[31:1]};
    assign lin_sat = (lin > CAP47) ? CAP47[46:0] : lin[46:0];

    assign q_sum = {1'b0, p_reg[47:0]} + {17'b0, lo_reg[31:0]};
    assign q_r   = ((|p_reg[64:48]) || q_sum[48]) ? CAP48 : q_sum[47:0];

    assign o_sum = {2'b0, p_reg[30:0], 16'b0} + {1'b0, lo_reg};
    assign o_sat = ((|p_reg[64:31]) || (|o_sum[48:47])) ? CAP47[46:0] : o_sum[46:0];

    assign contrib = (cfg.use_weights && ow_neg_reg) ? (~{2'b0, e_reg} + 49'd1)
                                                     : {2'b0, e_reg};
    assign acc_sum = {sum_reg[47], sum_reg} + contrib;
    assign acc_sat = (acc_sum[48] != acc_sum[47]) ? (acc_sum[48] ? NEG_MIN : CAP47)
                                                  : acc_sum[47:0];

    assign f_sum  = {p_reg[34:0], 16'b0} + {3'b0, lo_reg};
    assign f_big  = |f_sum[50:47];
    assign f_over = (|f_sum[50:48]) || (f_sum[47] && (|f_sum[46:0]));
    assign f_loss = sum_reg[47] ? (f_over ? NEG_MIN : (~f_sum[47:0] + 48'd1))
                                : (f_big ? CAP47 : f_sum[47:0]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = cfg.use_weights ? ST_WMUL : ST_CLASS;
                end
            end
            ST_WMUL:  state_next = ST_WFIX;
            ST_WFIX:  state_next = ST_CLASS;
            ST_CLASS:
            begin
                if (m_lt)
                begin
                    state_next = ST_QSQ;
                end
                else
                begin
                    state_next = cfg.use_weights ? ST_OLO : ST_ACC;
                end
            end
            ST_QSQ:   state_next = ST_QLO;
            ST_QLO:   state_next = ST_QHI;
            ST_QHI:   state_next = ST_QFIX;
            ST_QFIX:  state_next = cfg.use_weights ? ST_OLO : ST_ACC;
            ST_OLO:   state_next = ST_OHI;
            ST_OHI:   state_next = ST_OFIX;
            ST_OFIX:  state_next = ST_ACC;
            ST_ACC:   state_next = last_reg ? ST_FMAG : ST_IDLE;
            ST_FMAG:  state_next = ST_FLO;
            ST_FLO:   state_next = ST_FHI;
            ST_FHI:   state_next = ST_FFIX;
            ST_FFIX:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_rd           = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        mul_en         = 1'b0;
        m_next         = m_reg;
        iw_next        = iw_reg;
        ow_next        = ow_reg;
        ow_neg_next    = ow_neg_reg;
        last_next      = last_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        e_next         = e_reg;
        sum_next       = sum_reg;
        loss_next      = loss_reg;
        res_valid_next = res_valid_reg & ~pop;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_rd        = ~q_empty;
                m_next      = {15'b0, q_item.diff_mag};
                iw_next     = q_item.iw_mag;
                ow_next     = q_item.ow_mag;
                ow_neg_next = q_item.ow_neg;
                last_next   = q_item.last;
            end
            ST_WMUL:
            begin
                mul_en = 1'b1;
                mul_a  = m_reg[32:0];
                mul_b  = iw_reg;
            end
            ST_WFIX:
            begin
                m_next = p_reg[63:16];
            end
            ST_CLASS:
            begin
                if (!m_lt)
                begin
                    e_next = lin_sat;
                end
            end
            ST_QSQ:
            begin
                mul_en = 1'b1;
                mul_a  = {1'b0, m_reg[31:0]};
                mul_b  = m_reg[31:0];
            end
            ST_QLO:
            begin
                mul_en  = 1'b1;
                mul_a   = {1'b0, p_reg[31:0]};
                mul_b   = {1'b0, cfg.sigma_sq};
                hi_next = p_reg[63:32];
            end
            ST_QHI:
            begin
                mul_en  = 1'b1;
                mul_a   = {1'b0, hi_reg};
                mul_b   = {1'b0, cfg.sigma_sq};
                lo_next = {16'b0, p_reg[63:32]};
            end
            ST_QFIX:
            begin
                e_next = q_r[47:1];
            end
            ST_OLO:
            begin
                mul_en = 1'b1;
                mul_a  = {1'b0, e_reg[31:0]};
                mul_b  = ow_reg;
            end
            ST_OHI:
            begin
                mul_en  = 1'b1;
                mul_a   = {18'b0, e_reg[46:32]};
                mul_b   = ow_reg;
                lo_next = p_reg[63:16];
            end
            ST_OFIX:
            begin
                e_next = o_sat;
            end
            ST_ACC:
            begin
                sum_next = acc_sat;
            end
            ST_FMAG:
            begin
                m_next = sum_reg[47] ? (~sum_reg + 48'd1) : sum_reg;
            end
            ST_FLO:
            begin
                mul_en = 1'b1;
                mul_a  = {1'b0, m_reg[31:0]};
                mul_b  = {15'b0, cfg.inv_batch};
            end
            ST_FHI:
            begin
                mul_en  = 1'b1;
                mul_a   = {17'b0, m_reg[47:32]};
                mul_b   = {15'b0, cfg.inv_batch};
                lo_next = p_reg[63:16];
            end
            ST_FFIX:
            begin
                if (emit)
                begin
                    loss_next      = f_loss;
                    res_valid_next = 1'b1;
                    sum_next       = '0;
                end
            end
            default:
            begin
                q_rd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        iw_reg     <= iw_next;
        ow_reg     <= ow_next;
        ow_neg_reg <= ow_neg_next;
        last_reg   <= last_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        e_reg      <= e_next;
        loss_reg   <= loss_next;
        if (mul_en)
        begin
            p_reg <= {32'b0, mul_a} * {33'b0, mul_b};
        end
    end

    `SLR_ASSERT(a_mag_range, (state_reg == ST_CLASS) |-> (m_reg <= NEG_MIN),
                "weighted magnitude out of range")
    `SLR_ASSERT(a_sum_clear, emit |=> (sum_reg == '0), "accumulator not cleared")
    `SLR_ASSERT(a_qfix_order, (state_reg == ST_QFIX) |-> ($past(state_reg) == ST_QHI),
                "quadratic combine out of order")

endmodule

[hdl/smooth_l1_loss_reduce_core.sv]
// ----------------------------------------------------------------------------
// Smooth L1 loss reduce core
// Forward smooth L1 loss over a stream of Q16.16 elements, reduced into a
// saturating Q32.16 sum and scaled by the inverse batch size on the last beat.
// ----------------------------------------------------------------------------
// Each element runs through the back-end sequencer around one shared 33x32
// multiplier: a linear-region element goes straight to accumulation, a
// quadratic-region element takes three products for the quadratic term,
// weights on add one product for the inside weight and two for the outside
// weight; a last element then also runs through the steps of the final
// scaling. A queue of QUEUE_DEPTH entries in front and a one-entry result
// register behind let input beats and result beats proceed independently.
// Configuration registers: 0 sigma_sq, 1 inv_sigma_sq, 2 inv_batch,
// 3 use_weights; write them only while the core is idle.
// ----------------------------------------------------------------------------
module smooth_l1_loss_reduce_core
    import slr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] prediction,
    input  logic signed [31:0] target,
    input  logic signed [31:0] inside_weight,
    input  logic signed [31:0] outside_weight,
    input  logic               last_element,
    output logic               empty,
    input  logic               pop,
    output logic signed [47:0] loss,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    slr_cfg_t    cfg_reg;
    slr_cfg_t    cfg_next;
    logic        item_wr;
    slr_item_t   item;
    slr_item_t   q_item;
    logic        q_rd;
    logic        q_empty;
    logic [47:0] loss_bits;

    assign cfg_ready = 1'b1;
    assign loss      = $signed(loss_bits);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (slr_reg_idx_t'(cfg_index))
                REG_SIGMA_SQ:     cfg_next.sigma_sq     = cfg_data[30:0];
                REG_INV_SIGMA_SQ: cfg_next.inv_sigma_sq = cfg_data;
                REG_INV_BATCH:    cfg_next.inv_batch    = cfg_data[16:0];
                REG_USE_WEIGHTS:  cfg_next.use_weights  = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sigma_sq     <= 31'd65536;
            cfg_reg.inv_sigma_sq <= 32'd65536;
            cfg_reg.inv_batch    <= 17'd65536;
            cfg_reg.use_weights  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    slr_front u_front
    (
        .push           (push),
        .full           (full),
        .prediction     (prediction),
        .target         (target),
        .inside_weight  (inside_weight),
        .outside_weight (outside_weight),
        .last_element   (last_element),
        .item_wr        (item_wr),
        .item           (item)
    );

    slr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (item_wr),
        .wr_item (item),
        .full    (full),
        .rd      (q_rd),
        .rd_item (q_item),
        .empty   (q_empty)
    );

    slr_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_item  (q_item),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .loss    (loss_bits)
    );

endmodule
